@@ hdl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and the arctangent table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF     = 16;
	localparam int CORDIC_STAGES_DEF   = 16;

	// internal component format, Q1.14 in 16 bits
	localparam int COMP_W    = 16;
	// cordic x/y datapath width, covers operand range and gain
	localparam int CORDIC_W  = 38;
	// binary angle accumulator, 2^31 is pi
	localparam int PHASE_W   = 32;
	// square root steps, one result bit each
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_W     = 64;

	localparam int THR_W = 14;
	localparam logic [THR_W-1:0] THR_RESET = 14'd8176;

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic        [PHASE_W-1:0]  z;
		logic                       zero;
	} cordic_t;

	typedef struct packed {
		logic [SQRT_W-1:0] rem;
		logic [SQRT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] hy;
		logic signed [CORDIC_W-1:0] hx;
		logic signed [CORDIC_W-1:0] by;
		logic signed [CORDIC_W-1:0] bx;
		logic        [31:0]         a;
		logic        [31:0]         b;
		pole_t                      pole;
	} side_t;

	localparam logic [PHASE_W-1:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

endpackage

@@ hdl/qte_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One step of the digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  qte_pkg::sqrt_t din,
	output qte_pkg::sqrt_t dout
);
	import qte_pkg::*;

	localparam logic [SQRT_W-1:0] ONE = SQRT_W'(1) << (2 * STEP);

	logic [SQRT_W-1:0] trial;
	sqrt_t             nxt;

	always_comb begin
		trial = din.root + ONE;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = (din.root >> 1) + ONE;
		end else begin
			nxt.rem  = din.rem;
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

@@ hdl/qte_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring rotation of the arctangent cordic, registered.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic             clk,
	input  logic             en,
	input  qte_pkg::cordic_t din,
	output qte_pkg::cordic_t dout
);
	import qte_pkg::*;

	cordic_t nxt;

	always_comb begin
		nxt = din;
		if (!din.y[CORDIC_W-1]) begin
			nxt.x = din.x + (din.y >>> SHIFT);
			nxt.y = din.y - (din.x >>> SHIFT);
			nxt.z = din.z + ATAN_TAB[SHIFT];
		end else begin
			nxt.x = din.x - (din.y >>> SHIFT);
			nxt.y = din.y + (din.x >>> SHIFT);
			nxt.z = din.z - ATAN_TAB[SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

@@ hdl/quaternion_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Converts one quaternion to heading, attitude and bank per cycle while the
// output is not stalled, through a chain of square root and cordic cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  quat_w quat_x quat_y quat_z
//  out      source     out_valid/out_stall  heading/attitude/bank, pole_case
//  cfg      sink       cfg_valid/cfg_ready  cfg_data (pole threshold)
//
// one transaction per cycle while out_stall is low; the pipeline is built from
// the 32 square root cells and the cordic cell chain
// every stage holds its own valid bit and loads when it is empty or the
// stage after it moves, so bubbles close up while the output is stalled
// reset clears the valid bits and loads the default threshold
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top #(
	parameter int COMPONENT_WIDTH = qte_pkg::COMPONENT_WIDTH_DEF,
	parameter int ANGLE_WIDTH     = qte_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
	input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
	input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
	input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ANGLE_WIDTH-1:0]     heading_angle,
	output logic signed [ANGLE_WIDTH-1:0]     attitude_angle,
	output logic signed [ANGLE_WIDTH-1:0]     bank_angle,
	output logic [1:0]                        pole_case,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qte_pkg::THR_W-1:0]         cfg_data
);
	import qte_pkg::*;

	// stage numbers
	localparam int ST_SQ0 = 5;
	localparam int ST_ATT = ST_SQ0 + SQRT_STEPS;
	localparam int ST_PRE = ST_ATT + 1;
	localparam int ST_CR0 = ST_PRE + 1;
	localparam int LAST   = ST_CR0 + CORDIC_STAGES;
	localparam int RSH    = PHASE_W - ANGLE_WIDTH;
	localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

	// ------------------------------------------------------------------
	// handshake: per-stage valid with bubble collapse
	// ------------------------------------------------------------------
	logic [LAST:1]   v_q;
	logic [LAST+1:1] go;
	logic [LAST-1:0] v_in;

	assign go[LAST+1] = ~out_stall;
	assign v_in       = {v_q[LAST-1:1], in_valid};

	for (genvar k = 1; k <= LAST; k++) begin : g_ctl
		assign go[k] = ~v_q[k] | go[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (go[k]) begin
				v_q[k] <= v_in[k-1];
			end
		end
	end

	assign in_stall  = ~go[1];
	assign out_valid = v_q[LAST];

	// ------------------------------------------------------------------
	// configuration: threshold register, always ready
	// ------------------------------------------------------------------
	logic [THR_W-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// input scaling to Q1.14
	// ------------------------------------------------------------------
	logic signed [COMP_W-1:0] cw, cx, cy, cz;

	if (COMPONENT_WIDTH > COMP_W) begin : g_narrow
		localparam int DS = COMPONENT_WIDTH - COMP_W;
		logic signed [COMPONENT_WIDTH-1:0] tw, tx, ty, tz;
		always_comb begin
			tw = quat_w >>> DS;
			tx = quat_x >>> DS;
			ty = quat_y >>> DS;
			tz = quat_z >>> DS;
			cw = tw[COMP_W-1:0];
			cx = tx[COMP_W-1:0];
			cy = ty[COMP_W-1:0];
			cz = tz[COMP_W-1:0];
		end
	end else begin : g_widen
		localparam int US = COMP_W - COMPONENT_WIDTH;
		always_comb begin
			cw = COMP_W'(quat_w) <<< US;
			cx = COMP_W'(quat_x) <<< US;
			cy = COMP_W'(quat_y) <<< US;
			cz = COMP_W'(quat_z) <<< US;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: products
	// ------------------------------------------------------------------
	logic signed [31:0] zy_s1, xw_s1, yw_s1, zx_s1, zw_s1, yx_s1;
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [COMP_W-1:0] w_s1, z_s1;

	always_ff @(posedge clk) begin
		if (go[1]) begin
			zy_s1 <= cz * cy;
			xw_s1 <= cx * cw;
			yw_s1 <= cy * cw;
			zx_s1 <= cz * cx;
			zw_s1 <= cz * cw;
			yx_s1 <= cy * cx;
			ww_s1 <= cw * cw;
			xx_s1 <= cx * cx;
			yy_s1 <= cy * cy;
			zz_s1 <= cz * cz;
			w_s1  <= cw;
			z_s1  <= cz;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: pole test, norm and the atan2 operands
	// ------------------------------------------------------------------
	logic signed [33:0]         t_s2;
	logic signed [35:0]         unit_s2;
	logic signed [CORDIC_W-1:0] hy_s2, hx_s2, by_s2, bx_s2, pw_s2, pz_s2;

	always_ff @(posedge clk) begin
		if (go[2]) begin
			t_s2    <= 34'(zy_s1) + 34'(xw_s1);
			unit_s2 <= 36'(ww_s1) + 36'(xx_s1) + 36'(yy_s1) + 36'(zz_s1);
			hy_s2   <= (CORDIC_W'(yw_s1) - CORDIC_W'(zx_s1)) <<< 1;
			hx_s2   <= CORDIC_W'(zz_s1) - CORDIC_W'(yy_s1) - CORDIC_W'(xx_s1)
				+ CORDIC_W'(ww_s1);
			by_s2   <= (CORDIC_W'(zw_s1) - CORDIC_W'(yx_s1)) <<< 1;
			bx_s2   <= CORDIC_W'(yy_s1) + CORDIC_W'(ww_s1) - CORDIC_W'(zz_s1)
				- CORDIC_W'(xx_s1);
			pw_s2   <= CORDIC_W'(w_s1);
			pz_s2   <= CORDIC_W'(z_s1);
		end
	end

	// ------------------------------------------------------------------
	// stage 3: pole decision, asin terms a and b, heading operand select
	// ------------------------------------------------------------------
	logic signed [33:0] thr_w;
	logic signed [35:0] two_t, am, bm;
	logic               north, south;
	side_t              side_s3;

	always_comb begin
		thr_w = $signed({6'b0, thr_q, 14'b0});
		north = t_s2 > thr_w;
		south = t_s2 < -thr_w;
		two_t = 36'(t_s2) <<< 1;
		am    = (unit_s2 - two_t) >>> 2;
		bm    = (unit_s2 + two_t) >>> 2;
	end

	always_ff @(posedge clk) begin
		if (go[3]) begin
			side_s3.a    <= am[35] ? '0 : am[31:0];
			side_s3.b    <= bm[35] ? '0 : bm[31:0];
			side_s3.pole <= north ? POLE_NORTH : (south ? POLE_SOUTH : POLE_NONE);
			side_s3.hy   <= (north || south) ? pz_s2 : hy_s2;
			side_s3.hx   <= (north || south) ? pw_s2 : hx_s2;
			side_s3.by   <= by_s2;
			side_s3.bx   <= bx_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: a*b, then the square root cell chain
	// ------------------------------------------------------------------
	logic [SQRT_W-1:0] ab_s4;
	side_t             side_q [4:ST_ATT];
	sqrt_t             sq     [ST_SQ0-1:ST_ATT-1];

	always_ff @(posedge clk) begin
		if (go[4]) begin
			ab_s4     <= SQRT_W'(side_s3.a) * SQRT_W'(side_s3.b);
			side_q[4] <= side_s3;
		end
	end

	assign sq[ST_SQ0-1].rem  = ab_s4;
	assign sq[ST_SQ0-1].root = '0;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		qte_sqrt_cell #(
			.STEP(SQRT_STEPS - 1 - j)
		) u_cell (
			.clk (clk),
			.en  (go[ST_SQ0+j]),
			.din (sq[ST_SQ0-1+j]),
			.dout(sq[ST_SQ0+j])
		);
		always_ff @(posedge clk) begin
			if (go[ST_SQ0+j]) begin
				side_q[ST_SQ0+j] <= side_q[ST_SQ0-1+j];
			end
		end
	end

	// ------------------------------------------------------------------
	// attitude operands: atan2(b - a, 2*sqrt(a*b))
	// ------------------------------------------------------------------
	logic signed [CORDIC_W-1:0] ay_s37, ax_s37;
	logic [31:0]                root_w;

	// a*b stays below 2^62, so the root fits in 31 bits
	assign root_w = sq[ST_ATT-1].root[31:0];

	always_ff @(posedge clk) begin
		if (go[ST_ATT]) begin
			ay_s37 <= $signed({6'b0, side_q[ST_ATT-1].b})
				- $signed({6'b0, side_q[ST_ATT-1].a});
			ax_s37 <= $signed({5'b0, root_w, 1'b0});
			side_q[ST_ATT] <= side_q[ST_ATT-1];
		end
	end

	// ------------------------------------------------------------------
	// cordic entry: fold negative x into the right half plane
	// ------------------------------------------------------------------
	function automatic cordic_t fold(input logic signed [CORDIC_W-1:0] y,
		input logic signed [CORDIC_W-1:0] x);
		cordic_t r;
		r.zero = (x == '0) && (y == '0);
		if (x[CORDIC_W-1]) begin
			r.x = -x;
			r.y = -y;
			r.z = {1'b1, {(PHASE_W-1){1'b0}}};
		end else begin
			r.x = x;
			r.y = y;
			r.z = '0;
		end
		return r;
	endfunction

	cordic_t hd [ST_PRE:LAST-1];
	cordic_t at [ST_PRE:LAST-1];
	cordic_t bk [ST_PRE:LAST-1];
	pole_t   pole_q [ST_PRE:LAST-1];

	always_ff @(posedge clk) begin
		if (go[ST_PRE]) begin
			hd[ST_PRE]     <= fold(side_q[ST_ATT].hy, side_q[ST_ATT].hx);
			at[ST_PRE]     <= fold(ay_s37, ax_s37);
			bk[ST_PRE]     <= fold(side_q[ST_ATT].by, side_q[ST_ATT].bx);
			pole_q[ST_PRE] <= side_q[ST_ATT].pole;
		end
	end

	// three cordic chains in lockstep
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		if (ST_CR0 + i < LAST) begin : g_mid
			qte_cordic_cell #(.SHIFT(i)) u_hd (
				.clk(clk), .en(go[ST_CR0+i]), .din(hd[ST_PRE+i]), .dout(hd[ST_CR0+i])
			);
			qte_cordic_cell #(.SHIFT(i)) u_at (
				.clk(clk), .en(go[ST_CR0+i]), .din(at[ST_PRE+i]), .dout(at[ST_CR0+i])
			);
			qte_cordic_cell #(.SHIFT(i)) u_bk (
				.clk(clk), .en(go[ST_CR0+i]), .din(bk[ST_PRE+i]), .dout(bk[ST_CR0+i])
			);
			always_ff @(posedge clk) begin
				if (go[ST_CR0+i]) begin
					pole_q[ST_CR0+i] <= pole_q[ST_PRE+i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// output stage: round the binary angle and pick pole results
	// ------------------------------------------------------------------
	function automatic logic [ANGLE_WIDTH-1:0] to_angle(input cordic_t c);
		logic [PHASE_W-1:0] r;
		if (RSH > 0) begin
			r = c.z + (PHASE_W'(1) << (RSH - 1));
		end else begin
			r = c.z;
		end
		r = r >> RSH;
		return c.zero ? '0 : r[ANGLE_WIDTH-1:0];
	endfunction

	logic signed [ANGLE_WIDTH-1:0] heading_q, attitude_q, bank_q;
	pole_t                         pole_out_q;

	always_ff @(posedge clk) begin
		if (go[LAST]) begin
			heading_q  <= to_angle(hd[LAST-1]);
			pole_out_q <= pole_q[LAST-1];
			unique case (pole_q[LAST-1])
				POLE_NORTH: begin
					attitude_q <= QUARTER;
					bank_q     <= '0;
				end
				POLE_SOUTH: begin
					attitude_q <= -QUARTER;
					bank_q     <= '0;
				end
				default: begin
					attitude_q <= to_angle(at[LAST-1]);
					bank_q     <= to_angle(bk[LAST-1]);
				end
			endcase
		end
	end

	assign heading_angle  = heading_q;
	assign attitude_angle = attitude_q;
	assign bank_angle     = bank_q;
	assign pole_case      = pole_out_q;

`ifndef SYNTHESIS
	a_pole_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pole_case != 2'd3)
		else $error("invalid pole code");

	a_pole_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pole_case != POLE_NONE |-> bank_angle == '0)
		else $error("bank nonzero at pole");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		v_q == '0 |-> !in_stall)
		else $error("stall with empty pipeline");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && out_stall) |-> out_valid)
		else $error("stalled transaction dropped");
`endif

endmodule
